[rtl/bpa_pkg.sv]
package bpa_pkg;

  localparam int MAX_PAGES  = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam int ADDR_W = 32;
  localparam int CNT_W  = 11;
  localparam int POOL_W = 11;
  localparam int STAT_W = 2;

  localparam int POOL_RESET = 1024;

  // used map is kept as 32-bit words
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WORDS     = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PG_W      = WADDR_W + BIT_W;
  localparam int POS_W     = PG_W + 1;
  localparam int CMP_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam int FREE_W    = ADDR_W - PAGE_SHIFT;
  localparam int FCMP_W    = ((FREE_W > CNT_W) ? FREE_W : CNT_W) + 1;

  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOROOM = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD    = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_PAGES   = 1'd1;

  typedef struct packed {
    logic              load_item;
    logic              scan_start;
    logic              scan_run;
    logic              mark_start;
    logic              mark_read;
    logic              mark_write;
    logic              clear_step;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
  } bpa_cmd_t;

  typedef struct packed {
    logic op_free;
    logic cnt_zero;
    logic alloc_bad;
    logic free_bad;
    logic scan_valid;
    logic scan_hit;
    logic scan_last;
    logic mark_last;
    logic clear_last;
  } bpa_sts_t;

endpackage

[rtl/bpa_ifs.sv]
interface bpa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [bpa_pkg::ADDR_W-1:0]     address;
  logic [bpa_pkg::CNT_W-1:0]      page_count;
  modport source (output valid, op, address, page_count, input ready);
  modport sink   (input valid, op, address, page_count, output ready);
endinterface

interface bpa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bpa_pkg::ADDR_W-1:0]     start_address;
  logic [bpa_pkg::STAT_W-1:0]     status;
  modport source (output valid, start_address, status, input ready);
  modport sink   (input valid, start_address, status, output ready);
endinterface

interface bpa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bpa_pkg::CFG_IDX_W-1:0]  index;
  logic [bpa_pkg::ADDR_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/bpa_ram.sv]
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bpa_datapath.sv]
module bpa_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  bpa_pkg::bpa_cmd_t               cmd,
  output bpa_pkg::bpa_sts_t               sts,
  input  logic                            in_op,
  input  logic [bpa_pkg::ADDR_W-1:0]      in_address,
  input  logic [bpa_pkg::CNT_W-1:0]       in_page_count,
  input  logic                            cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]      cfg_data,
  output logic [bpa_pkg::ADDR_W-1:0]      out_start_address,
  output logic [bpa_pkg::STAT_W-1:0]      out_status
);

  localparam int WB = bpa_pkg::WORD_BITS;
  localparam int BW = bpa_pkg::BIT_W;

  // configuration
  logic [bpa_pkg::ADDR_W-1:0] base_address;
  logic [bpa_pkg::POOL_W-1:0] pool_pages;

  // latched item
  logic                        op;
  logic [bpa_pkg::CNT_W-1:0]   count;
  logic                        below;
  logic [bpa_pkg::FREE_W-1:0]  start_pg;

  // scan
  logic [bpa_pkg::WADDR_W-1:0] rd_ptr;
  logic [bpa_pkg::WADDR_W-1:0] proc_w;
  logic                        pend;
  logic [bpa_pkg::POS_W-1:0]   run_start;
  logic [bpa_pkg::POS_W-1:0]   found;

  // mark / clear
  logic [bpa_pkg::PG_W-1:0]    lo;
  logic [bpa_pkg::PG_W-1:0]    hi;
  logic [bpa_pkg::WADDR_W-1:0] ptr;
  logic [bpa_pkg::WADDR_W-1:0] clr_ptr;

  // memory port
  logic                        ram_we;
  logic [bpa_pkg::WADDR_W-1:0] ram_waddr;
  logic [WB-1:0]               ram_wdata;
  logic [bpa_pkg::WADDR_W-1:0] ram_raddr;
  logic [WB-1:0]               ram_rdata;

  logic [bpa_pkg::POS_W-1:0]   size;
  logic [bpa_pkg::POS_W-1:0]   size_m1;
  logic [bpa_pkg::ADDR_W-1:0]  addr_diff;

  logic [bpa_pkg::POS_W-1:0]   gpos  [WB];
  logic [WB-1:0]               used;
  logic                        pv    [BW+1][WB];
  logic [bpa_pkg::POS_W-1:0]   ps    [BW+1][WB];
  logic [bpa_pkg::POS_W-1:0]   run_s [WB];
  logic [WB-1:0]               hit;
  logic [BW-1:0]               hit_sel;

  logic [bpa_pkg::PG_W-1:0]    lo_src;
  logic [bpa_pkg::CMP_W-1:0]   hi_sum;
  logic [BW-1:0]               lo_off;
  logic [BW-1:0]               hi_off;
  logic [WB-1:0]               mask;
  logic [WB-1:0]               merged;

  bpa_ram #(
    .WIDTH (WB),
    .DEPTH (bpa_pkg::WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (32'(pool_pages) > 32'(bpa_pkg::MAX_PAGES)) begin
      size = bpa_pkg::POS_W'(bpa_pkg::MAX_PAGES);
    end else begin
      size = bpa_pkg::POS_W'(pool_pages);
    end
    size_m1   = size - bpa_pkg::POS_W'(1);
    addr_diff = in_address - base_address;
  end

  // Run search over one word: a run ending at bit j started just after the
  // nearest used bit at or below j, else at the carried run start.
  always_comb begin
    for (int j = 0; j < WB; j++) begin
      gpos[j]  = {1'b0, proc_w, BW'(j)};
      used[j]  = ram_rdata[j] | (gpos[j] >= size);
      pv[0][j] = used[j];
      ps[0][j] = gpos[j] + bpa_pkg::POS_W'(1);
    end
    for (int l = 0; l < BW; l++) begin
      for (int j = 0; j < WB; j++) begin
        if (j >= (1 << l) && !pv[l][j]) begin
          pv[l+1][j] = pv[l][j - (1 << l)];
          ps[l+1][j] = ps[l][j - (1 << l)];
        end else begin
          pv[l+1][j] = pv[l][j];
          ps[l+1][j] = ps[l][j];
        end
      end
    end
    for (int j = 0; j < WB; j++) begin
      run_s[j] = pv[BW][j] ? ps[BW][j] : run_start;
      hit[j]   = !used[j] &&
                 (bpa_pkg::CMP_W'(gpos[j]) + bpa_pkg::CMP_W'(1) >=
                  bpa_pkg::CMP_W'(run_s[j]) + bpa_pkg::CMP_W'(count));
    end
    hit_sel = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (hit[j]) begin
        hit_sel = BW'(j);
      end
    end
  end

  // range to set or clear, one word per read-modify-write
  always_comb begin
    lo_src = (op == bpa_pkg::OP_FREE) ? start_pg[bpa_pkg::PG_W-1:0]
                                      : found[bpa_pkg::PG_W-1:0];
    hi_sum = bpa_pkg::CMP_W'(lo_src) + bpa_pkg::CMP_W'(count) - bpa_pkg::CMP_W'(1);
    lo_off = (ptr == lo[bpa_pkg::PG_W-1:BW]) ? lo[BW-1:0] : '0;
    hi_off = (ptr == hi[bpa_pkg::PG_W-1:BW]) ? hi[BW-1:0] : BW'(WB - 1);
    mask   = ({WB{1'b1}} << lo_off) & ({WB{1'b1}} >> (BW'(WB - 1) - hi_off));
    merged = (op == bpa_pkg::OP_FREE) ? (ram_rdata & ~mask) : (ram_rdata | mask);

    ram_we    = cmd.clear_step | cmd.mark_write;
    ram_waddr = cmd.clear_step ? clr_ptr : ptr;
    ram_wdata = cmd.clear_step ? '0 : merged;
    ram_raddr = cmd.mark_read ? ptr : rd_ptr;
  end

  always_comb begin
    sts.op_free    = (op == bpa_pkg::OP_FREE);
    sts.cnt_zero   = (count == '0);
    sts.alloc_bad  = bpa_pkg::CMP_W'(count) > bpa_pkg::CMP_W'(size);
    sts.free_bad   = below ||
                     (bpa_pkg::FCMP_W'(start_pg) + bpa_pkg::FCMP_W'(count) >
                      bpa_pkg::FCMP_W'(size));
    sts.scan_valid = pend;
    sts.scan_hit   = |hit;
    sts.scan_last  = (proc_w == size_m1[bpa_pkg::PG_W-1:BW]);
    sts.mark_last  = (ptr == hi[bpa_pkg::PG_W-1:BW]);
    sts.clear_last = (clr_ptr == bpa_pkg::WADDR_W'(bpa_pkg::WORDS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      pool_pages   <= bpa_pkg::POOL_W'(bpa_pkg::POOL_RESET);
      pend         <= 1'b0;
      clr_ptr      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bpa_pkg::REG_BASE_ADDRESS: base_address <= cfg_data;
          bpa_pkg::REG_POOL_PAGES:   pool_pages   <= cfg_data[bpa_pkg::POOL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.scan_start) begin
        pend <= 1'b0;
      end else if (cmd.scan_run) begin
        pend <= 1'b1;
      end
      if (cmd.clear_step) begin
        clr_ptr <= clr_ptr + bpa_pkg::WADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op       <= in_op;
      count    <= in_page_count;
      below    <= in_address < base_address;
      start_pg <= addr_diff[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
    end
    if (cmd.scan_start) begin
      rd_ptr    <= '0;
      run_start <= '0;
    end else if (cmd.scan_run) begin
      rd_ptr <= rd_ptr + bpa_pkg::WADDR_W'(1);
      proc_w <= rd_ptr;
      if (pend) begin
        run_start <= run_s[WB-1];
        if (|hit) begin
          found <= run_s[hit_sel];
        end
      end
    end
    if (cmd.mark_start) begin
      lo  <= lo_src;
      hi  <= hi_sum[bpa_pkg::PG_W-1:0];
      ptr <= lo_src[bpa_pkg::PG_W-1:BW];
    end else if (cmd.mark_write) begin
      ptr <= ptr + bpa_pkg::WADDR_W'(1);
    end
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      if (cmd.out_status == bpa_pkg::ST_DONE && op == bpa_pkg::OP_ALLOC) begin
        out_start_address <= base_address +
                             bpa_pkg::ADDR_W'(found) *
                             bpa_pkg::ADDR_W'(bpa_pkg::PAGE_BYTES);
      end else begin
        out_start_address <= '0;
      end
    end
  end

endmodule

[rtl/bpa_ctrl.sv]
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bpa_pkg::bpa_cmd_t cmd,
  input  bpa_pkg::bpa_sts_t sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MSET  = 3'd4;
  localparam logic [2:0] S_MRD   = 3'd5;
  localparam logic [2:0] S_MWR   = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [bpa_pkg::STAT_W-1:0]  code;
  logic [bpa_pkg::STAT_W-1:0]  code_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    code_next  = code;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.cnt_zero) begin
          code_next  = bpa_pkg::ST_BAD;
          state_next = S_RESP;
        end else if (sts.op_free) begin
          if (sts.free_bad) begin
            code_next  = bpa_pkg::ST_BAD;
            state_next = S_RESP;
          end else begin
            state_next = S_MSET;
          end
        end else if (sts.alloc_bad) begin
          code_next  = bpa_pkg::ST_BAD;
          state_next = S_RESP;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_valid) begin
          if (sts.scan_hit) begin
            state_next = S_MSET;
          end else if (sts.scan_last) begin
            code_next  = bpa_pkg::ST_NOROOM;
            state_next = S_RESP;
          end
        end
      end
      S_MSET: begin
        cmd.mark_start = 1'b1;
        state_next     = S_MRD;
      end
      S_MRD: begin
        cmd.mark_read = 1'b1;
        state_next    = S_MWR;
      end
      S_MWR: begin
        cmd.mark_write = 1'b1;
        if (sts.mark_last) begin
          code_next  = bpa_pkg::ST_DONE;
          state_next = S_RESP;
        end else begin
          state_next = S_MRD;
        end
      end
      S_RESP: begin
        // output slot must be free or draining this cycle
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = code;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      code      <= bpa_pkg::ST_DONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/bitmap_page_allocator_unit.sv]
// Channel   Role    Payload
// req       sink    op, address, page_count
// rsp       source  start_address, status
// cfg       sink    index, data (0 base_address, 1 pool_pages)
//
// One request at a time. After acceptance a check state runs, then allocate scans the
// used map one 32-page word per cycle up to the first fit, behind the registered RAM
// read; marking or freeing takes a set-up state, then a read and a write per map word
// the run touches, and a response state loads the result.
// After reset the map RAM is swept to zero, one word per cycle (WORDS = 32 words);
// req.ready stays low meanwhile, cfg is always ready.
// The result sits in an output register; a stalled rsp holds the next request
// only once that request has its own result ready.
module bitmap_page_allocator_unit (
  input logic      clk,
  input logic      rst,
  bpa_req_if.sink  req,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink  cfg
);

  bpa_pkg::bpa_cmd_t cmd;
  bpa_pkg::bpa_sts_t sts;

  assign cfg.ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bpa_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (req.op),
    .in_address        (req.address),
    .in_page_count     (req.page_count),
    .cfg_we            (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .out_start_address (rsp.start_address),
    .out_status        (rsp.status)
  );

endmodule
